// ===== rtl/core/rlfbe_pkg.sv =====
package rlfbe_pkg;

    // Frame geometry
    localparam int LED_COUNT    = 16;
    localparam int LED_IDX_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int BITS_PER_LED = 24;
    localparam int BIT_SEL_W    = $clog2(BITS_PER_LED);
    localparam int LEN_W        = $clog2(LED_COUNT * BITS_PER_LED + 1);
    localparam int COLOR_W      = 24;

    // Field widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 8;
    localparam int CHAN_W     = 8;
    localparam int RATE_W     = 4;
    localparam int CODE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // LED index that addresses the whole frame
    localparam logic [IDX_W-1:0] ALL_LEDS = 8'hFF;

    // Register reset values
    localparam logic [RATE_W-1:0] RATE_RST = 4'd1;
    localparam logic [CODE_W-1:0] ONE_RST  = 16'd60;
    localparam logic [CODE_W-1:0] ZERO_RST = 16'd30;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_RATE  = 2'd0,
        REG_ONE_CODE  = 2'd1,
        REG_ZERO_CODE = 2'd2
    } t_reg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    // Coarse quantisation, brightness multiply and saturation of one channel
    function automatic logic [CHAN_W-1:0] scale_channel(input logic [CHAN_W-1:0] v,
                                                        input logic [RATE_W-1:0] rate);
        logic [4:0]  q;
        logic [8:0]  p;
        logic [11:0] s;
        q = 5'((9'(v) + 9'd1) >> 4);
        p = 9'(q) * 9'(rate);
        s = (12'(p) << 3) + (12'(p) << 1);
        return (s > 12'd255) ? 8'hFF : s[CHAN_W-1:0];
    endfunction

endpackage

// ===== rtl/core/rlfbe_if.sv =====
// Command channel
interface rlfbe_in_if;
    import rlfbe_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [IDX_W-1:0]  led_index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    modport source (output valid, operation, led_index, red, green, blue, input ready);
    modport sink   (input valid, operation, led_index, red, green, blue, output ready);
endinterface

// Compare value channel
interface rlfbe_out_if;
    import rlfbe_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] compare_value;
    logic              last_bit;
    logic              busy_res;
    modport source (output valid, compare_value, last_bit, busy_res, input ready);
    modport sink   (input valid, compare_value, last_bit, busy_res, output ready);
endinterface

// Register write channel
interface rlfbe_cfg_if;
    import rlfbe_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rgb_led_frame_bit_encoder.sv =====
// Channel   Dir  Payload                                   Accepted when
// i_in      in   operation, led_index, red, green, blue    valid && ready
// o_out     out  compare_value, last_bit, busy_res         valid && ready
// i_cfg     in   index, data                               valid && ready
//
// Set and start commands pass through accept and execute; a tick passes through
// accept, colour memory read and result, as the registered read of the colour
// memory sits between address and bit select. One command is in flight at a time.
// A waiting result is held in the output register; the next command is
// accepted meanwhile, and only a further tick result waits for it to drain.
// Reset clears the per-LED written flags at once; no clearing pass is needed.
module rgb_led_frame_bit_encoder
    import rlfbe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlfbe_in_if.sink    i_in,
    rlfbe_out_if.source o_out,
    rlfbe_cfg_if.sink   i_cfg
);

    t_state r_state, n_state;

    // Captured command
    logic [OP_W-1:0]   r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [CHAN_W-1:0] r_red, r_green, r_blue;

    // Configuration
    logic [RATE_W-1:0] r_max_rate;
    logic [CODE_W-1:0] r_one_code, r_zero_code;

    // Frame colour memory; an entry not written since the last broadcast reads
    // as the broadcast colour
    logic [COLOR_W-1:0]   mem [LED_COUNT];
    logic [LED_COUNT-1:0] r_vld;
    logic [COLOR_W-1:0]   r_bcast;
    logic [COLOR_W-1:0]   r_rd_data;
    logic                 r_rd_vld;

    // Transfer state
    logic [LEN_W-1:0]     r_send_len, r_xfer_len, r_pos;
    logic [LED_IDX_W-1:0] r_led;
    logic [BIT_SEL_W-1:0] r_bit_sel;
    logic                 r_pending, r_sending;

    // Output register
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_cmp;
    logic              r_out_last, r_out_busy;

    // Sequencer controls
    logic s_in_ready, s_exec, s_mem_re, s_resp_fire;

    logic                 in_fire, out_free, idx_all, idx_one, active, last, cur_bit;
    logic [COLOR_W-1:0]   grb, word;
    logic [LEN_W-1:0]     pos_next, one_len;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Datapath for set and tick
    assign grb     = {scale_channel(r_green, r_max_rate), scale_channel(r_red, r_max_rate),
                      scale_channel(r_blue, r_max_rate)};
    assign idx_all = (r_idx == ALL_LEDS);
    assign idx_one = (32'(r_idx) < LED_COUNT);
    assign one_len = LEN_W'((LEN_W'(r_idx[LED_IDX_W-1:0]) + LEN_W'(1)) * BITS_PER_LED);
    assign word    = r_rd_vld ? r_rd_data : r_bcast;
    assign cur_bit = word[r_bit_sel];
    assign active  = r_sending && (r_pos < r_xfer_len);
    assign pos_next = r_pos + LEN_W'(1);
    assign last    = (pos_next >= r_xfer_len);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_fire) n_state = ST_EXEC;
            ST_EXEC: begin
                if (r_op == OP_TICK) n_state = ST_RESP;
                else                 n_state = ST_IDLE;
            end
            ST_RESP: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_in_ready  = 1'b0;
        s_exec      = 1'b0;
        s_mem_re    = 1'b0;
        s_resp_fire = 1'b0;
        case (r_state)
            ST_IDLE: s_in_ready = 1'b1;
            ST_EXEC: begin
                s_exec   = 1'b1;
                s_mem_re = (r_op == OP_TICK);
            end
            ST_RESP: s_resp_fire = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= i_in.operation;
            r_idx   <= i_in.led_index;
            r_red   <= i_in.red;
            r_green <= i_in.green;
            r_blue  <= i_in.blue;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rate  <= RATE_RST;
            r_one_code  <= ONE_RST;
            r_zero_code <= ZERO_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_MAX_RATE:  r_max_rate  <= i_cfg.data[RATE_W-1:0];
                REG_ONE_CODE:  r_one_code  <= i_cfg.data[CODE_W-1:0];
                REG_ZERO_CODE: r_zero_code <= i_cfg.data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Colour memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (s_exec && r_op == OP_SET && !idx_all && idx_one)
            mem[r_idx[LED_IDX_W-1:0]] <= grb;
        if (s_mem_re)
            r_rd_data <= mem[r_led];
    end

    // Written flags, broadcast colour, pending length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_bcast    <= '0;
            r_rd_vld   <= 1'b0;
            r_send_len <= '0;
            r_pending  <= 1'b0;
        end else begin
            if (s_mem_re) r_rd_vld <= r_vld[r_led];
            if (s_exec && r_op == OP_SET) begin
                if (idx_all) begin
                    r_vld      <= '0;
                    r_bcast    <= grb;
                    r_send_len <= LEN_W'(LED_COUNT * BITS_PER_LED);
                    r_pending  <= 1'b1;
                end else if (idx_one) begin
                    r_vld[r_idx[LED_IDX_W-1:0]] <= 1'b1;
                    r_send_len <= one_len;
                    r_pending  <= 1'b1;
                end
            end else if (s_exec && r_op == OP_START && r_pending && !r_sending) begin
                r_pending <= 1'b0;
            end
        end
    end

    // Transfer position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sending  <= 1'b0;
            r_xfer_len <= '0;
            r_pos      <= '0;
            r_led      <= '0;
            r_bit_sel  <= BIT_SEL_W'(BITS_PER_LED - 1);
        end else if (s_exec && r_op == OP_START && r_pending && !r_sending) begin
            r_sending  <= 1'b1;
            r_xfer_len <= r_send_len;
            r_pos      <= '0;
            r_led      <= '0;
            r_bit_sel  <= BIT_SEL_W'(BITS_PER_LED - 1);
        end else if (s_resp_fire) begin
            if (active) begin
                r_pos <= pos_next;
                if (r_bit_sel == '0) begin
                    r_bit_sel <= BIT_SEL_W'(BITS_PER_LED - 1);
                    r_led     <= r_led + LED_IDX_W'(1);
                end else begin
                    r_bit_sel <= r_bit_sel - BIT_SEL_W'(1);
                end
                if (last) r_sending <= 1'b0;
            end else begin
                r_sending <= 1'b0;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_resp_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_resp_fire) begin
            r_out_cmp  <= active ? (cur_bit ? r_one_code : r_zero_code) : '0;
            r_out_last <= active && last;
            r_out_busy <= active;
        end
    end

    assign i_in.ready          = s_in_ready;
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.compare_value = r_out_cmp;
    assign o_out.last_bit      = r_out_last;
    assign o_out.busy_res      = r_out_busy;

endmodule

// ===== rtl/core/rlfbe_checker.sv =====
module rlfbe_checker
    import rlfbe_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CODE_W-1:0] i_out_cmp,
    input logic              i_out_last,
    input logic              i_out_busy
);

    // A stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_cmp)
            && $stable(i_out_last) && $stable(i_out_busy))
        else $error("result changed while stalled");

    // The final bit is always part of a running transfer
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_busy)
        else $error("last bit outside a transfer");

    // An idle tick carries a zero compare
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_busy |-> i_out_cmp == '0 && !i_out_last)
        else $error("idle tick with non-zero compare");

    // One command at a time: no acceptance in the cycle after one
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while another executes");

endmodule

bind rgb_led_frame_bit_encoder rlfbe_checker u_rlfbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_cmp   (o_out.compare_value),
    .i_out_last  (o_out.last_bit),
    .i_out_busy  (o_out.busy_res)
);
